// ===== rtl/nhor_pkg.sv =====
package nhor_pkg;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_CENTER_X     = 3'd0;
	localparam cfg_index_t CFG_CENTER_Y     = 3'd1;
	localparam cfg_index_t CFG_CENTER_Z     = 3'd2;
	localparam cfg_index_t CFG_INNER_RADIUS = 3'd3;
	localparam cfg_index_t CFG_VIEW_MODE    = 3'd4;

	typedef logic [1:0] view_t;

	localparam view_t VIEW_X  = 2'd0;
	localparam view_t VIEW_Y  = 2'd1;
	localparam view_t VIEW_3D = 2'd2;

endpackage

// ===== rtl/nhor_hit_if.sv =====
interface nhor_hit_if #(
	parameter int COORD_BITS = 20,
	parameter int ID_BITS    = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] hit_x;
	logic signed [COORD_BITS-1:0] hit_y;
	logic signed [COORD_BITS-1:0] hit_z;
	logic        [ID_BITS-1:0]    hit_id;
	logic                         hit_valid;
	logic                         last;

	modport source (
		output valid, hit_x, hit_y, hit_z, hit_id, hit_valid, last,
		input  ready
	);

	modport sink (
		input  valid, hit_x, hit_y, hit_z, hit_id, hit_valid, last,
		output ready
	);
endinterface

// ===== rtl/nhor_near_if.sv =====
interface nhor_near_if #(
	parameter int COORD_BITS = 20,
	parameter int ID_BITS    = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] near_x;
	logic signed [COORD_BITS-1:0] near_y;
	logic signed [COORD_BITS-1:0] near_z;
	logic signed [ID_BITS:0]      near_id;
	logic                         found;

	modport source (
		output valid, near_x, near_y, near_z, near_id, found,
		input  ready
	);

	modport sink (
		input  valid, near_x, near_y, near_z, near_id, found,
		output ready
	);
endinterface

// ===== rtl/nhor_cfg.sv =====
module nhor_cfg #(
	parameter int COORD_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         we,
	input  nhor_pkg::cfg_index_t         index,
	input  logic [COORD_BITS-1:0]        data,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y,
	output logic signed [COORD_BITS-1:0] center_z,
	output logic [2*COORD_BITS-1:0]      radius_sq,
	output nhor_pkg::view_t              view
);
	import nhor_pkg::*;

	logic signed [COORD_BITS-1:0] center_x_q;
	logic signed [COORD_BITS-1:0] center_y_q;
	logic signed [COORD_BITS-1:0] center_z_q;
	logic [COORD_BITS-1:0]        radius_q;
	logic [2*COORD_BITS-1:0]      radius_sq_q;
	view_t                        view_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= '0;
			center_y_q  <= '0;
			center_z_q  <= '0;
			radius_q    <= '0;
			radius_sq_q <= '0;
			view_q      <= VIEW_3D;
		end else begin
			// The squared radius is registered from the radius register and follows it in the next cycle.
			radius_sq_q <= (2*COORD_BITS)'(radius_q) * (2*COORD_BITS)'(radius_q);
			if (we) begin
				unique case (index)
					CFG_CENTER_X:     center_x_q <= data;
					CFG_CENTER_Y:     center_y_q <= data;
					CFG_CENTER_Z:     center_z_q <= data;
					CFG_INNER_RADIUS: radius_q   <= data;
					CFG_VIEW_MODE:    view_q     <= data[1:0];
					default: ;
				endcase
			end
		end
	end

	assign center_x  = center_x_q;
	assign center_y  = center_y_q;
	assign center_z  = center_z_q;
	assign radius_sq = radius_sq_q;
	assign view      = view_q;

endmodule

// ===== rtl/nearest_hit_outside_radius.sv =====
// Keeps, over the hits of one plane, the hit nearest to the configured centre whose squared
// distance (in the X or Y view, along that axis alone) is strictly greater than the squared
// inner radius, and on the item marked last delivers that hit (or id -1, zero position and
// found low if none qualified), then starts afresh. One item is accepted every clock cycle
// unless output back-pressure stalls the pipeline; an item passes absolute-difference,
// squaring and distance registers before the running-best compare and output register.
// The three squarers, each COORD_BITS by COORD_BITS, set the cycle time. The pipeline keeps
// taking items while a result waits, until a last item stalls in the distance register.
// The user must write configuration only while idle; the block does not enforce this.
module nearest_hit_outside_radius #(
	parameter int COORD_BITS = 20,
	parameter int ID_BITS    = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	nhor_hit_if.sink                 hit,
	nhor_near_if.source              near,
	input  logic                     cfg_we,
	input  nhor_pkg::cfg_index_t     cfg_index,
	input  logic [COORD_BITS-1:0]    cfg_data
);
	import nhor_pkg::*;

	localparam int SQ_BITS   = 2 * COORD_BITS;
	localparam int DIST_BITS = SQ_BITS + 2;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic [COORD_BITS:0]        m;
		d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
		m = d[COORD_BITS] ? -d : d;
		return m[COORD_BITS-1:0];
	endfunction

	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] center_z;
	logic [SQ_BITS-1:0]           radius_sq;
	view_t                        view;

	nhor_cfg #(
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (cfg_we),
		.index     (cfg_index),
		.data      (cfg_data),
		.center_x  (center_x),
		.center_y  (center_y),
		.center_z  (center_z),
		.radius_sq (radius_sq),
		.view      (view)
	);

	// Stage 1: absolute differences.
	logic                         valid_s1;
	logic [COORD_BITS-1:0]        adx_s1, ady_s1, adz_s1;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic [ID_BITS-1:0]           id_s1;
	logic                         hv_s1, last_s1;

	// Stage 2: squares.
	logic                         valid_s2;
	logic [SQ_BITS-1:0]           sqx_s2, sqy_s2, sqz_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2, z_s2;
	logic [ID_BITS-1:0]           id_s2;
	logic                         hv_s2, last_s2;

	// Stage 3: squared distance.
	logic                         valid_s3;
	logic [DIST_BITS-1:0]         dist_s3;
	logic signed [COORD_BITS-1:0] x_s3, y_s3, z_s3;
	logic [ID_BITS-1:0]           id_s3;
	logic                         hv_s3, last_s3;

	// Running best.
	logic                         have_best_q;
	logic [DIST_BITS-1:0]         best_dist_q;
	logic signed [COORD_BITS-1:0] best_x_q, best_y_q, best_z_q;
	logic [ID_BITS-1:0]           best_id_q;

	// Output register.
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] near_x_q, near_y_q, near_z_q;
	logic signed [ID_BITS:0]      near_id_q;
	logic                         found_q;

	logic                 out_free, ret_s3, adv_s2, adv_s1, load_s2, load_s3, accept;
	logic [DIST_BITS-1:0] dist_w;
	logic                 outside, closer, take, new_have;

	assign out_free = !out_valid_q || near.ready;
	assign ret_s3   = valid_s3 && (!last_s3 || out_free);
	assign load_s3  = !valid_s3 || ret_s3;
	assign adv_s2   = valid_s2 && load_s3;
	assign load_s2  = !valid_s2 || adv_s2;
	assign adv_s1   = valid_s1 && load_s2;
	assign hit.ready = !valid_s1 || adv_s1;
	assign accept   = hit.valid && hit.ready;

	always_comb begin
		case (view)
			VIEW_X:  dist_w = DIST_BITS'(sqx_s2);
			VIEW_Y:  dist_w = DIST_BITS'(sqy_s2);
			default: dist_w = DIST_BITS'(sqx_s2) + DIST_BITS'(sqy_s2) + DIST_BITS'(sqz_s2);
		endcase
	end

	assign outside  = dist_s3 > DIST_BITS'(radius_sq);
	assign closer   = !have_best_q || (dist_s3 < best_dist_q);
	assign take     = hv_s3 && outside && closer;
	assign new_have = have_best_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			have_best_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (hit.ready) begin
				valid_s1 <= hit.valid;
			end
			if (load_s2) begin
				valid_s2 <= adv_s1;
			end
			if (load_s3) begin
				valid_s3 <= adv_s2;
			end
			if (ret_s3) begin
				if (last_s3) begin
					have_best_q <= 1'b0;
				end else if (take) begin
					have_best_q <= 1'b1;
				end
			end
			if (out_free) begin
				out_valid_q <= ret_s3 && last_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			adx_s1  <= abs_diff(hit.hit_x, center_x);
			ady_s1  <= abs_diff(hit.hit_y, center_y);
			adz_s1  <= abs_diff(hit.hit_z, center_z);
			x_s1    <= hit.hit_x;
			y_s1    <= hit.hit_y;
			z_s1    <= hit.hit_z;
			id_s1   <= hit.hit_id;
			hv_s1   <= hit.hit_valid;
			last_s1 <= hit.last;
		end
		if (adv_s1) begin
			sqx_s2  <= SQ_BITS'(adx_s1) * SQ_BITS'(adx_s1);
			sqy_s2  <= SQ_BITS'(ady_s1) * SQ_BITS'(ady_s1);
			sqz_s2  <= SQ_BITS'(adz_s1) * SQ_BITS'(adz_s1);
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			id_s2   <= id_s1;
			hv_s2   <= hv_s1;
			last_s2 <= last_s1;
		end
		if (adv_s2) begin
			dist_s3 <= dist_w;
			x_s3    <= x_s2;
			y_s3    <= y_s2;
			z_s3    <= z_s2;
			id_s3   <= id_s2;
			hv_s3   <= hv_s2;
			last_s3 <= last_s2;
		end
		if (ret_s3 && !last_s3 && take) begin
			best_dist_q <= dist_s3;
			best_x_q    <= x_s3;
			best_y_q    <= y_s3;
			best_z_q    <= z_s3;
			best_id_q   <= id_s3;
		end
		if (ret_s3 && last_s3) begin
			found_q <= new_have;
			if (take) begin
				near_x_q  <= x_s3;
				near_y_q  <= y_s3;
				near_z_q  <= z_s3;
				near_id_q <= $signed({1'b0, id_s3});
			end else if (have_best_q) begin
				near_x_q  <= best_x_q;
				near_y_q  <= best_y_q;
				near_z_q  <= best_z_q;
				near_id_q <= $signed({1'b0, best_id_q});
			end else begin
				near_x_q  <= '0;
				near_y_q  <= '0;
				near_z_q  <= '0;
				near_id_q <= '1;
			end
		end
	end

	assign near.valid   = out_valid_q;
	assign near.near_x  = near_x_q;
	assign near.near_y  = near_y_q;
	assign near.near_z  = near_z_q;
	assign near.near_id = near_id_q;
	assign near.found   = found_q;

endmodule
